[hw/rtl/sseq_pkg.sv]
// shared types and constants of the stable sorted event queue
// no dependencies; imported by sseq_cell, stable_sorted_event_queue, sseq_checker and the testbench
`timescale 1ns / 1ps

package sseq_pkg;

   // default sizes, handed down through the top level parameters
   localparam int DEF_CAPACITY    = 32;
   localparam int DEF_SOURCE_BITS = 4;
   localparam int DEF_TIME_BITS   = 48;

   // request operation codes
   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_PUSH  = 2'd1,
      OP_POP   = 2'd2,
      OP_NONE  = 2'd3
   } sseq_op_type;

   // response status codes
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_RSVD  = 2'd3
   } sseq_status_type;

   // per-cycle command broadcast to every cell of the chain
   typedef struct packed {
      logic push;
      logic pop;
   } sseq_ctrl_type;

endpackage

[hw/rtl/sseq_cell.sv]
// one slot of the sorted chain: holds one event, compares it with the pushed time
// and trades contents with its neighbors; depends on sseq_pkg
`timescale 1ns / 1ps

module sseq_cell #(
   parameter int TIME_BITS   = 48,
   parameter int SOURCE_BITS = 4
) (
   input  logic                      clock,
   input  sseq_pkg::sseq_ctrl_type   ctrl,
   input  logic                      occupied,
   // event being pushed
   input  logic [TIME_BITS-1:0]      new_time,
   input  logic                      new_kind,
   input  logic [SOURCE_BITS-1:0]    new_source,
   // left neighbor (earlier slot)
   input  logic                      left_gt,
   input  logic [TIME_BITS-1:0]      left_time,
   input  logic                      left_kind,
   input  logic [SOURCE_BITS-1:0]    left_source,
   // right neighbor (later slot)
   input  logic [TIME_BITS-1:0]      right_time,
   input  logic                      right_kind,
   input  logic [SOURCE_BITS-1:0]    right_source,
   // own contents
   output logic                      gt,
   output logic [TIME_BITS-1:0]      slot_time,
   output logic                      slot_kind,
   output logic [SOURCE_BITS-1:0]    slot_source
);
   import sseq_pkg::*;

   logic [TIME_BITS-1:0]   time_ff, time_in;
   logic                   kind_ff, kind_in;
   logic [SOURCE_BITS-1:0] source_ff, source_in;

   // stored event is strictly later than the pushed one, so it moves right
   assign gt = occupied && (time_ff > new_time);

   // select next contents
   always_comb begin
      time_in   = time_ff;
      kind_in   = kind_ff;
      source_in = source_ff;
      if (ctrl.pop) begin
         time_in   = right_time;
         kind_in   = right_kind;
         source_in = right_source;
      end else if (ctrl.push) begin
         if (left_gt) begin
            time_in   = left_time;
            kind_in   = left_kind;
            source_in = left_source;
         end else if (gt || !occupied) begin
            time_in   = new_time;
            kind_in   = new_kind;
            source_in = new_source;
         end
      end
   end

   // payload storage, no reset needed
   always_ff @(posedge clock) begin
      time_ff   <= time_in;
      kind_ff   <= kind_in;
      source_ff <= source_in;
   end

   assign slot_time   = time_ff;
   assign slot_kind   = kind_ff;
   assign slot_source = source_ff;

endmodule

[hw/rtl/stable_sorted_event_queue.sv]
// top level of the stable sorted event queue: count, command decode, response register
// and the chain of sseq_cell slots; depends on sseq_pkg and sseq_cell
`timescale 1ns / 1ps

// Future-event list kept in ascending time order in a row of CAPACITY cells.
// Request channel: start with req_operation and the event fields; a request is
// taken at a rising edge with start high and busy low. busy stays low, so a new
// request may come in every cycle.
// Operations: clear empties the list, push inserts behind all events of equal
// or smaller time (equal times leave first in, first out), pop removes the
// earliest event. A push into a full list is dropped with status full; a pop
// of an empty list reports status empty.
// Response channel: rsp_strobe is high for exactly one cycle, the cycle after
// the request was taken, together with status, popped event and entry count.
// Throughput is one request per cycle: every cell compares its own time with the
// pushed time and shifts in the same cycle.
// The receiver cannot stall; a response is gone after its cycle.
// Reset empties the list and clears the strobe; slot contents are not cleared.
module stable_sorted_event_queue #(
   parameter int CAPACITY    = sseq_pkg::DEF_CAPACITY,
   parameter int SOURCE_BITS = sseq_pkg::DEF_SOURCE_BITS,
   parameter int TIME_BITS   = sseq_pkg::DEF_TIME_BITS,
   localparam int COUNT_BITS = $clog2(CAPACITY + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   start,
   output logic                   busy,
   input  logic [1:0]             req_operation,
   input  logic [TIME_BITS-1:0]   req_event_time,
   input  logic                   req_event_kind,
   input  logic [SOURCE_BITS-1:0] req_source_id,
   // response channel
   output logic                   rsp_strobe,
   output logic [1:0]             rsp_status,
   output logic [TIME_BITS-1:0]   rsp_popped_time,
   output logic                   rsp_popped_kind,
   output logic [SOURCE_BITS-1:0] rsp_popped_source,
   output logic [COUNT_BITS-1:0]  rsp_entry_count
);
   import sseq_pkg::*;

   localparam logic [COUNT_BITS-1:0] FULL_COUNT = COUNT_BITS'(CAPACITY);

   sseq_op_type            op;
   sseq_ctrl_type          ctrl;
   logic                   accept;
   logic                   full;
   logic                   empty;

   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic                   strobe_ff, strobe_in;
   sseq_status_type        status_ff, status_in;
   logic [TIME_BITS-1:0]   ptime_ff, ptime_in;
   logic                   pkind_ff, pkind_in;
   logic [SOURCE_BITS-1:0] psource_ff, psource_in;

   logic                   cell_gt     [CAPACITY];
   logic                   cell_occ    [CAPACITY];
   logic [TIME_BITS-1:0]   cell_time   [CAPACITY];
   logic                   cell_kind   [CAPACITY];
   logic [SOURCE_BITS-1:0] cell_source [CAPACITY];

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign op     = sseq_op_type'(req_operation);
   assign full   = (count_ff == FULL_COUNT);
   assign empty  = (count_ff == '0);

   // command decode for the chain
   always_comb begin
      ctrl.push = accept && (op == OP_PUSH) && !full;
      ctrl.pop  = accept && (op == OP_POP) && !empty;
   end

   // next count and response contents
   always_comb begin
      count_in   = count_ff;
      strobe_in  = accept;
      status_in  = ST_OK;
      ptime_in   = '0;
      pkind_in   = 1'b0;
      psource_in = '0;
      if (accept) begin
         unique case (op)
            OP_CLEAR: count_in = '0;
            OP_PUSH: begin
               if (full) status_in = ST_FULL;
               else      count_in  = count_ff + 1'b1;
            end
            OP_POP: begin
               if (empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  count_in   = count_ff - 1'b1;
                  ptime_in   = cell_time[0];
                  pkind_in   = cell_kind[0];
                  psource_in = cell_source[0];
               end
            end
            default: count_in = count_ff;
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   // response payload registers
   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      ptime_ff   <= ptime_in;
      pkind_ff   <= pkind_in;
      psource_ff <= psource_in;
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_status        = status_ff;
   assign rsp_popped_time   = ptime_ff;
   assign rsp_popped_kind   = pkind_ff;
   assign rsp_popped_source = psource_ff;
   assign rsp_entry_count   = count_ff;

   // chain of cells, slot 0 holds the earliest event
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                   left_gt;
      logic [TIME_BITS-1:0]   left_time, right_time;
      logic                   left_kind, right_kind;
      logic [SOURCE_BITS-1:0] left_source, right_source;

      assign cell_occ[i] = (count_ff > COUNT_BITS'(i));

      if (i == 0) begin : g_head
         assign left_gt     = 1'b0;
         assign left_time   = '0;
         assign left_kind   = 1'b0;
         assign left_source = '0;
      end else begin : g_body
         assign left_gt     = cell_gt[i-1];
         assign left_time   = cell_time[i-1];
         assign left_kind   = cell_kind[i-1];
         assign left_source = cell_source[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_time   = cell_time[i];
         assign right_kind   = cell_kind[i];
         assign right_source = cell_source[i];
      end else begin : g_inner
         assign right_time   = cell_time[i+1];
         assign right_kind   = cell_kind[i+1];
         assign right_source = cell_source[i+1];
      end

      sseq_cell #(
         .TIME_BITS   (TIME_BITS),
         .SOURCE_BITS (SOURCE_BITS)
      ) u_cell (
         .clock        (clock),
         .ctrl         (ctrl),
         .occupied     (cell_occ[i]),
         .new_time     (req_event_time),
         .new_kind     (req_event_kind),
         .new_source   (req_source_id),
         .left_gt      (left_gt),
         .left_time    (left_time),
         .left_kind    (left_kind),
         .left_source  (left_source),
         .right_time   (right_time),
         .right_kind   (right_kind),
         .right_source (right_source),
         .gt           (cell_gt[i]),
         .slot_time    (cell_time[i]),
         .slot_kind    (cell_kind[i]),
         .slot_source  (cell_source[i])
      );
   end

   // every taken request gets exactly one response in the next cycle
   a_one_response: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("request without response");

   // no response without a request
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_strobe)
      else $error("response without request");

   // the count never passes the capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count above capacity");

   // a successful pop removes exactly one event
   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      ctrl.pop |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("pop did not remove one event");

   // a dropped push leaves a full list
   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == ST_FULL) |-> (count_ff == FULL_COUNT))
      else $error("push dropped while not full");

endmodule

[dv/sseq_checker.sv]
// response checker of the stable sorted event queue: keeps its own sorted event list
// and compares every response with it; depends on sseq_pkg
`timescale 1ns / 1ps

module sseq_checker #(
   parameter int CAPACITY    = sseq_pkg::DEF_CAPACITY,
   parameter int SOURCE_BITS = sseq_pkg::DEF_SOURCE_BITS,
   parameter int TIME_BITS   = sseq_pkg::DEF_TIME_BITS,
   localparam int COUNT_BITS = $clog2(CAPACITY + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   busy,
   input  logic [1:0]             req_operation,
   input  logic [TIME_BITS-1:0]   req_event_time,
   input  logic                   req_event_kind,
   input  logic [SOURCE_BITS-1:0] req_source_id,
   input  logic                   rsp_strobe,
   input  logic [1:0]             rsp_status,
   input  logic [TIME_BITS-1:0]   rsp_popped_time,
   input  logic                   rsp_popped_kind,
   input  logic [SOURCE_BITS-1:0] rsp_popped_source,
   input  logic [COUNT_BITS-1:0]  rsp_entry_count,
   output int                     fail_count,
   output int                     pending_count
);
   import sseq_pkg::*;

   typedef struct packed {
      sseq_status_type        status;
      logic [TIME_BITS-1:0]   ev_time;
      logic                   ev_kind;
      logic [SOURCE_BITS-1:0] ev_source;
      logic [COUNT_BITS-1:0]  count;
   } queue_reply_type;

   // shadow event list, slot 0 earliest
   logic [TIME_BITS-1:0]   list_time   [CAPACITY];
   logic                   list_kind   [CAPACITY];
   logic [SOURCE_BITS-1:0] list_source [CAPACITY];
   int                     list_fill;

   queue_reply_type replies_due[$];
   int              mismatches;

   // apply one request to the shadow list and return the response it should give
   function automatic queue_reply_type apply_list_request(input sseq_op_type op,
         input logic [TIME_BITS-1:0] t, input logic k, input logic [SOURCE_BITS-1:0] s);
      queue_reply_type r;
      int pos;
      r = '0;
      r.status = ST_OK;
      case (op)
         OP_CLEAR: begin
            list_fill = 0;
         end
         OP_PUSH: begin
            if (list_fill >= CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               // insert behind every event of equal or smaller time
               pos = 0;
               while (pos < list_fill && list_time[pos] <= t) pos++;
               for (int i = list_fill; i > pos; i--) begin
                  list_time[i]   = list_time[i-1];
                  list_kind[i]   = list_kind[i-1];
                  list_source[i] = list_source[i-1];
               end
               list_time[pos]   = t;
               list_kind[pos]   = k;
               list_source[pos] = s;
               list_fill++;
            end
         end
         OP_POP: begin
            if (list_fill == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.ev_time   = list_time[0];
               r.ev_kind   = list_kind[0];
               r.ev_source = list_source[0];
               for (int i = 1; i < list_fill; i++) begin
                  list_time[i-1]   = list_time[i];
                  list_kind[i-1]   = list_kind[i];
                  list_source[i-1] = list_source[i];
               end
               list_fill--;
            end
         end
         default: ;
      endcase
      r.count = COUNT_BITS'(list_fill);
      return r;
   endfunction

   // response compare first, then record the request taken at this edge
   always @(posedge clock) begin : watch
      queue_reply_type want;
      if (reset) begin
         list_fill = 0;
         mismatches = 0;
         replies_due.delete();
      end else begin
         if (rsp_strobe) begin
            if (replies_due.size() == 0) begin
               mismatches++;
               $error("response with no request outstanding");
            end else begin
               want = replies_due.pop_front();
               if (rsp_status !== want.status) begin
                  mismatches++;
                  $error("rsp_status: expected %0d, got %0d", want.status, rsp_status);
               end
               if (rsp_popped_time !== want.ev_time) begin
                  mismatches++;
                  $error("rsp_popped_time: expected %h, got %h", want.ev_time, rsp_popped_time);
               end
               if (rsp_popped_kind !== want.ev_kind) begin
                  mismatches++;
                  $error("rsp_popped_kind: expected %0d, got %0d", want.ev_kind, rsp_popped_kind);
               end
               if (rsp_popped_source !== want.ev_source) begin
                  mismatches++;
                  $error("rsp_popped_source: expected %0d, got %0d",
                         want.ev_source, rsp_popped_source);
               end
               if (rsp_entry_count !== want.count) begin
                  mismatches++;
                  $error("rsp_entry_count: expected %0d, got %0d", want.count, rsp_entry_count);
               end
            end
         end
         if (start && !busy) begin
            replies_due.push_back(apply_list_request(sseq_op_type'(req_operation),
                  req_event_time, req_event_kind, req_source_id));
         end
      end
      fail_count    <= mismatches;
      pending_count <= replies_due.size();
   end

endmodule

[dv/stable_sorted_event_queue_tb.sv]
// testbench top of the stable sorted event queue: clock, reset, request stimulus and verdict
// depends on sseq_pkg, sseq_checker and stable_sorted_event_queue
`timescale 1ns / 1ps

module stable_sorted_event_queue_tb;
   import sseq_pkg::*;

   localparam int CAPACITY      = DEF_CAPACITY;
   localparam int SOURCE_BITS   = DEF_SOURCE_BITS;
   localparam int TIME_BITS     = DEF_TIME_BITS;
   localparam int COUNT_BITS    = $clog2(CAPACITY + 1);
   localparam int REQUEST_TOTAL = 2000;
   localparam int STALL_LIMIT   = 500;

   typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX, MODE_NOISE} burst_mode_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [1:0]             req_operation = OP_NONE;
   logic [TIME_BITS-1:0]   req_event_time = '0;
   logic                   req_event_kind = 1'b0;
   logic [SOURCE_BITS-1:0] req_source_id = '0;
   logic                   rsp_strobe;
   logic [1:0]             rsp_status;
   logic [TIME_BITS-1:0]   rsp_popped_time;
   logic                   rsp_popped_kind;
   logic [SOURCE_BITS-1:0] rsp_popped_source;
   logic [COUNT_BITS-1:0]  rsp_entry_count;
   int                     fail_count;
   int                     pending_count;

   stable_sorted_event_queue uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_event_time    (req_event_time),
      .req_event_kind    (req_event_kind),
      .req_source_id     (req_source_id),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_popped_time   (rsp_popped_time),
      .rsp_popped_kind   (rsp_popped_kind),
      .rsp_popped_source (rsp_popped_source),
      .rsp_entry_count   (rsp_entry_count)
   );

   sseq_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_event_time    (req_event_time),
      .req_event_kind    (req_event_kind),
      .req_source_id     (req_source_id),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_popped_time   (rsp_popped_time),
      .rsp_popped_kind   (rsp_popped_kind),
      .rsp_popped_source (rsp_popped_source),
      .rsp_entry_count   (rsp_entry_count),
      .fail_count        (fail_count),
      .pending_count     (pending_count)
   );

   always #5 clock = ~clock;

   // watchdog: ends the run after too many cycles without any handshake
   always @(posedge clock) begin : watchdog
      int stall;
      if (reset || (start && !busy) || rsp_strobe) begin
         stall = 0;
      end else begin
         stall++;
         if (stall >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // idle length: mostly none, some short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // event time: extremes, a cluster around the burst anchor, or anything
   function automatic logic [TIME_BITS-1:0] pick_time(input logic [TIME_BITS-1:0] anchor);
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3, 4: return anchor + TIME_BITS'($urandom_range(0, 3));
         default: return TIME_BITS'({$urandom, $urandom});
      endcase
   endfunction

   function automatic sseq_op_type pick_op(input burst_mode_type mode);
      int r;
      r = $urandom_range(0, 199);
      if (r == 0) return OP_CLEAR;
      if (r == 1) return OP_NONE;
      r = r / 2;
      case (mode)
         MODE_FILL:  return (r < 88) ? OP_PUSH : OP_POP;
         MODE_DRAIN: return (r < 85) ? OP_POP : OP_PUSH;
         MODE_MIX:   return (r < 52) ? OP_PUSH : OP_POP;
         default:    return sseq_op_type'($urandom_range(0, 3));
      endcase
   endfunction

   // one request: idle for gap cycles, then hold start until it is taken
   task automatic send_request(input sseq_op_type op, input logic [TIME_BITS-1:0] t,
         input logic k, input logic [SOURCE_BITS-1:0] s, input int gap);
      repeat (gap) begin
         @(negedge clock);
         start          <= 1'b0;
         req_operation  <= 2'($urandom_range(0, 3));
         req_event_time <= TIME_BITS'({$urandom, $urandom});
         req_event_kind <= 1'($urandom);
      end
      @(negedge clock);
      start          <= 1'b1;
      req_operation  <= op;
      req_event_time <= t;
      req_event_kind <= k;
      req_source_id  <= s;
      do @(posedge clock); while (busy);
   endtask

   // stop sending until every outstanding response has come back
   task automatic wait_for_replies();
      @(negedge clock);
      start <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   initial begin : stimulus
      logic [TIME_BITS-1:0] tie;
      logic [TIME_BITS-1:0] anchor;
      burst_mode_type       mode;
      int                   sent;
      int                   burst_len;
      bit                   gapless;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty pop, extremes, equal-time order, unused code, clear
      tie = TIME_BITS'(48'h0000_0001_8000);
      send_request(OP_POP,   '0,  1'b0, '0,   0);
      send_request(OP_PUSH,  '1,  1'b1, '1,   0);
      send_request(OP_PUSH,  '0,  1'b0, '0,   0);
      send_request(OP_PUSH,  tie, 1'b0, 4'd1, 0);
      send_request(OP_PUSH,  tie, 1'b0, 4'd2, 1);
      send_request(OP_PUSH,  tie, 1'b0, 4'd3, 0);
      send_request(OP_PUSH,  tie, 1'b1, 4'd4, 0);
      send_request(OP_NONE,  tie, 1'b1, 4'd9, 0);
      repeat (6) send_request(OP_POP, '0, 1'b0, '0, 0);
      send_request(OP_POP,   '0,  1'b0, '0,   2);
      send_request(OP_PUSH,  TIME_BITS'(5), 1'b1, 4'd5, 0);
      send_request(OP_PUSH,  TIME_BITS'(3), 1'b0, 4'd6, 0);
      send_request(OP_CLEAR, '1,  1'b1, '1,   0);
      send_request(OP_POP,   '0,  1'b0, '0,   0);
      send_request(OP_PUSH,  '1 - 1'b1, 1'b0, 4'd7, 0);
      send_request(OP_POP,   '0,  1'b0, '0,   0);
      wait_for_replies();

      // random bursts, mostly push-heavy or pop-heavy so the list fills and drains
      sent = 0;
      while (sent < REQUEST_TOTAL) begin
         mode      = burst_mode_type'($urandom_range(0, 9) < 4 ? MODE_FILL :
                     $urandom_range(0, 2) == 0 ? MODE_NOISE :
                     $urandom_range(0, 1) == 0 ? MODE_DRAIN : MODE_MIX);
         burst_len = $urandom_range(10, 70);
         anchor    = TIME_BITS'({$urandom, $urandom});
         gapless   = ($urandom_range(0, 3) == 0);
         repeat (burst_len) begin
            send_request(pick_op(mode), pick_time(anchor), 1'($urandom),
                         SOURCE_BITS'($urandom), gapless ? 0 : pick_gap());
            sent++;
         end
         if ($urandom_range(0, 6) == 0) wait_for_replies();
      end

      // drain and give the verdict
      wait_for_replies();
      repeat (5) @(negedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
